/* sv/message_slot_fifo_unit_defines.svh */
// ----------------------------------------------------------------------------
// Message slot FIFO assertion macros
// Shared property wrappers for the message slot FIFO blocks.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_SLOT_FIFO_UNIT_DEFINES_SVH
`define MESSAGE_SLOT_FIFO_UNIT_DEFINES_SVH

// same-cycle implication, idle during reset
`define MSF_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msf: same-cycle property failed");

// next-cycle implication, idle during reset
`define MSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msf: next-cycle property failed");

`endif

/* sv/msf_pkg.sv */
// ----------------------------------------------------------------------------
// msf_pkg
// Types and fixed field widths of the message slot FIFO.
// ----------------------------------------------------------------------------
package msf_pkg;

	localparam int BYTE_W = 8;
	localparam int OFS_W  = 10;
	localparam int STAT_W = 3;
	localparam int HLEN_W = 11;
	localparam int OCC_W  = 7;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_POP   = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_LONG   = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_OFFSET = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		DROP_NONE = 2'd0,
		DROP_FULL = 2'd1,
		DROP_LONG = 2'd2
	} drop_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_WAIT,
		S_LEN_WAIT,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_load;
		logic len_load;
		logic out_load;
	} msf_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_rd;
		logic need_len;
		logic out_free;
	} msf_stat_t;

	function automatic status_t drop_status(drop_t d);
		status_t s;
		unique case (d)
			DROP_FULL: s = ST_FULL;
			DROP_LONG: s = ST_LONG;
			default:   s = ST_OK;
		endcase
		return s;
	endfunction

endpackage

/* sv/msf_ram.sv */
// ----------------------------------------------------------------------------
// msf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/msf_ctrl.sv */
// ----------------------------------------------------------------------------
// msf_ctrl
// Item sequencer: capture, execute, optional memory read wait, result hand-off.
// ----------------------------------------------------------------------------
module msf_ctrl import msf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  msf_stat_t stat,
	output msf_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				priority if (stat.need_rd) begin
					state_d = S_RD_WAIT;
				end else if (stat.need_len) begin
					state_d = S_LEN_WAIT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_WAIT: begin
				cmd.rd_load = 1'b1;
				state_d     = S_DONE;
			end
			S_LEN_WAIT: begin
				cmd.len_load = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* sv/msf_dp.sv */
// ----------------------------------------------------------------------------
// msf_dp
// Ring pointers, write/drop tracking, byte and length stores, result register.
// ----------------------------------------------------------------------------
`include "message_slot_fifo_unit_defines.svh"

module msf_dp import msf_pkg::*; #(
	parameter int SLOT_BYTES = 1024,
	parameter int SLOT_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msf_cmd_t          cmd,
	output msf_stat_t         stat,
	input  opcode_t           in_opcode,
	input  logic [BYTE_W-1:0] in_data,
	input  logic              in_last,
	input  logic [OFS_W-1:0]  in_offset,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [STAT_W-1:0] out_status,
	output logic [BYTE_W-1:0] out_data,
	output logic [HLEN_W-1:0] out_hlen,
	output logic [OCC_W-1:0]  out_occ
);

	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int POS_W  = $clog2(SLOT_BYTES + 1);
	localparam int TOTAL  = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W = $clog2(TOTAL);

	// captured item
	opcode_t           op_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic [OFS_W-1:0]  ofs_q;

	// ring state
	logic [SLOT_W-1:0] head_q, tail_q;
	logic [ADDR_W-1:0] head_base_q, tail_base_q;
	logic [CNT_W-1:0]  count_q;
	logic [POS_W-1:0]  wpos_q;
	drop_t             drop_q;
	logic [POS_W-1:0]  hd_len_q;

	// staged result and output register
	status_t           res_status_q;
	logic [BYTE_W-1:0] res_data_q;
	logic              m_tvalid_q;

	logic [BYTE_W-1:0] byte_rdata;
	logic [POS_W-1:0]  len_rdata;

	logic              empty, full, store, commit, read_hit, pop_ok;
	drop_t             drop_n;
	logic [POS_W-1:0]  wpos_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic [SLOT_W-1:0] head_nx, tail_nx;
	logic [ADDR_W:0]   head_bsum, tail_bsum;
	logic [ADDR_W-1:0] head_base_nx, tail_base_nx;
	logic [ADDR_W+POS_W-1:0] wsum;
	logic [ADDR_W+OFS_W-1:0] rsum;
	logic [OFS_W+POS_W-1:0]  ofs_x, len_x;
	logic [POS_W+HLEN_W-1:0] hlen_x;
	logic [CNT_W+OCC_W-1:0]  occ_x;
	status_t           exec_status;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(SLOT_COUNT));
	assign wpos_inc = wpos_q + 1'b1;
	assign cnt_dec  = count_q - 1'b1;

	// ring full is only seen at the first byte; too long at the first extra byte
	always_comb begin
		drop_n = drop_q;
		if (drop_q == DROP_NONE) begin
			if (wpos_q == '0 && full) begin
				drop_n = DROP_FULL;
			end else if (wpos_q >= POS_W'(SLOT_BYTES)) begin
				drop_n = DROP_LONG;
			end
		end
	end

	assign store  = (op_q == OP_WRITE) && (drop_n == DROP_NONE);
	assign commit = store && last_q;

	assign ofs_x    = {{POS_W{1'b0}}, ofs_q};
	assign len_x    = {{OFS_W{1'b0}}, hd_len_q};
	// the head length never exceeds the slot size, so this also bounds the offset
	assign read_hit = (op_q == OP_READ) && !empty && (ofs_x < len_x);
	assign pop_ok   = (op_q == OP_POP) && !empty;

	assign head_nx = (head_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : tail_q + 1'b1;

	assign head_bsum    = {1'b0, head_base_q} + (ADDR_W + 1)'(SLOT_BYTES);
	assign tail_bsum    = {1'b0, tail_base_q} + (ADDR_W + 1)'(SLOT_BYTES);
	assign head_base_nx = (head_bsum == (ADDR_W + 1)'(TOTAL)) ? '0 : head_bsum[ADDR_W-1:0];
	assign tail_base_nx = (tail_bsum == (ADDR_W + 1)'(TOTAL)) ? '0 : tail_bsum[ADDR_W-1:0];

	assign wsum = {{POS_W{1'b0}}, tail_base_q} + {{ADDR_W{1'b0}}, wpos_q};
	assign rsum = {{OFS_W{1'b0}}, head_base_q} + {{ADDR_W{1'b0}}, ofs_q};

	assign stat.need_rd  = read_hit;
	assign stat.need_len = pop_ok && (cnt_dec != '0);
	assign stat.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		unique case (op_q)
			OP_WRITE: exec_status = drop_status(drop_n);
			OP_READ:  exec_status = empty ? ST_EMPTY : (read_hit ? ST_OK : ST_OFFSET);
			OP_POP:   exec_status = empty ? ST_EMPTY : ST_OK;
			OP_NONE:  exec_status = ST_OK;
			default:  exec_status = ST_OK;
		endcase
	end

	msf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TOTAL)
	) u_byte_ram (
		.clk   (clk),
		.we    (cmd.exec && store),
		.waddr (wsum[ADDR_W-1:0]),
		.wdata (byte_q),
		.re    (cmd.exec && read_hit),
		.raddr (rsum[ADDR_W-1:0]),
		.rdata (byte_rdata)
	);

	// only entries of committed messages are ever read back
	msf_ram #(
		.WIDTH (POS_W),
		.DEPTH (SLOT_COUNT)
	) u_len_ram (
		.clk   (clk),
		.we    (cmd.exec && commit),
		.waddr (tail_q),
		.wdata (wpos_inc),
		.re    (cmd.exec && stat.need_len),
		.raddr (head_nx),
		.rdata (len_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_opcode;
			byte_q <= in_data;
			last_q <= in_last;
			ofs_q  <= in_offset;
		end
		if (cmd.exec) begin
			res_status_q <= exec_status;
			res_data_q   <= '0;
		end
		if (cmd.rd_load) begin
			res_data_q <= byte_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			head_base_q <= '0;
			tail_base_q <= '0;
			count_q     <= '0;
			wpos_q      <= '0;
			drop_q      <= DROP_NONE;
			hd_len_q    <= '0;
		end else begin
			if (cmd.exec && op_q == OP_WRITE) begin
				if (last_q) begin
					if (store) begin
						tail_q      <= tail_nx;
						tail_base_q <= tail_base_nx;
						count_q     <= count_q + 1'b1;
						// first message into an empty ring becomes the head
						if (empty) begin
							hd_len_q <= wpos_inc;
						end
					end
					wpos_q <= '0;
					drop_q <= DROP_NONE;
				end else begin
					if (store) begin
						wpos_q <= wpos_inc;
					end
					drop_q <= drop_n;
				end
			end
			if (cmd.exec && pop_ok) begin
				head_q      <= head_nx;
				head_base_q <= head_base_nx;
				count_q     <= cnt_dec;
			end
			if (cmd.len_load) begin
				hd_len_q <= len_rdata;
			end
		end
	end

	assign hlen_x = {{HLEN_W{1'b0}}, (empty ? {POS_W{1'b0}} : hd_len_q)};
	assign occ_x  = {{OCC_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status <= res_status_q;
			out_data   <= res_data_q;
			out_hlen   <= hlen_x[HLEN_W-1:0];
			out_occ    <= occ_x[OCC_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;

	`MSF_ASSERT_HOLD(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(SLOT_COUNT))
	`MSF_ASSERT_HOLD(a_empty_aligned, clk, arst_n, count_q == '0, head_q == tail_q && head_base_q == tail_base_q)
	`MSF_ASSERT_HOLD(a_wpos_range, clk, arst_n, 1'b1, wpos_q <= POS_W'(SLOT_BYTES))
	`MSF_ASSERT_HOLD(a_load_when_free, clk, arst_n, cmd.out_load, !m_tvalid_q || m_tready)
	`MSF_ASSERT_NEXT(a_read_follows, clk, arst_n, cmd.exec && read_hit, cmd.rd_load)

endmodule

/* sv/message_slot_fifo_unit.sv */
// Sequence: an input item is captured and executed; a read that hits the byte store
// or a pop that loads the next head length then waits on the registered RAM read, and
// the result is loaded into the output register once it is free. A new item is taken
// only after the previous result is loaded, as set by the controller sequence.
// Reset: pointers, message count, write position, drop state and output valid clear
// asynchronously; slot contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// message_slot_fifo_unit
// Ring of fixed-size message slots with per-slot lengths, byte write/read and pop.
// ----------------------------------------------------------------------------
module message_slot_fifo_unit import msf_pkg::*; #(
	parameter int SLOT_BYTES = 1024,
	parameter int SLOT_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // data_byte[7:0], read_offset[17:8], zero pad
	input  logic [1:0]  s_tuser,  // opcode[1:0]
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // status[2:0], read_data[10:3], head_length[21:11],
	                              // occupancy[28:22], zero pad
);

	msf_cmd_t          cmd;
	msf_stat_t         stat;
	logic [STAT_W-1:0] out_status;
	logic [BYTE_W-1:0] out_data;
	logic [HLEN_W-1:0] out_hlen;
	logic [OCC_W-1:0]  out_occ;

	msf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	msf_dp #(
		.SLOT_BYTES (SLOT_BYTES),
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (opcode_t'(s_tuser)),
		.in_data    (s_tdata[7:0]),
		.in_last    (s_tlast),
		.in_offset  (s_tdata[17:8]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_status (out_status),
		.out_data   (out_data),
		.out_hlen   (out_hlen),
		.out_occ    (out_occ)
	);

	assign m_tdata = {3'b000, out_occ, out_hlen, out_data, out_status};

endmodule
